// File: rtl/diec_pkg.sv
// Shared types and constants for the debounced input edge counter.
// Depends on nothing; every other file in rtl imports it.
`default_nettype none

package diec_pkg;

  // Width of the internal wrapping event counters.
  localparam int unsigned COUNT_WIDTH = 16;
  // Width of each counter field in the result word.
  localparam int unsigned OUT_CNT_W   = 16;
  localparam int unsigned STABLE_W    = 16;
  localparam int unsigned NUM_EVT     = 5;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  // Flag and counter positions.
  localparam int unsigned EVT_CHANGED     = 0;
  localparam int unsigned EVT_RISEN       = 1;
  localparam int unsigned EVT_FALLEN      = 2;
  localparam int unsigned EVT_ACTIVATED   = 3;
  localparam int unsigned EVT_DEACTIVATED = 4;

  // Register indexes on the configuration port.
  localparam logic REG_DEBOUNCE_TICKS = 1'b0;
  localparam logic REG_IDLE_LEVEL     = 1'b1;

  localparam logic [STABLE_W-1:0] DEBOUNCE_RESET = STABLE_W'(50);
  localparam logic                IDLE_RESET     = 1'b1;
  localparam logic [STABLE_W-1:0] STABLE_MAX     = '1;

  typedef struct packed {
    logic [STABLE_W-1:0] debounce_ticks;
    logic                idle_level;
  } cfg_t;

  typedef struct packed {
    logic [NUM_EVT-1:0][OUT_CNT_W-1:0] counts;
    logic [NUM_EVT-1:0]                flags;
    logic                              debounced_level;
  } res_t;

endpackage : diec_pkg

`default_nettype wire

// File: rtl/diec_cfg.sv
// APB-style register file holding the debounce setting and the idle level.
// Depends on diec_pkg.
`default_nettype none

module diec_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [diec_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [diec_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [diec_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output diec_pkg::cfg_t                       cfg
);
  import diec_pkg::*;

  logic [STABLE_W-1:0] debounce_r;
  logic                idle_r;
  logic                wr_en;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      idle_r     <= IDLE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DEBOUNCE_TICKS: debounce_r <= pwdata[STABLE_W-1:0];
        REG_IDLE_LEVEL:     idle_r     <= pwdata[0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE_TICKS: prdata = APB_DATA_W'(debounce_r);
      REG_IDLE_LEVEL:     prdata = APB_DATA_W'(idle_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg.debounce_ticks = debounce_r;
  assign cfg.idle_level     = idle_r;

endmodule : diec_cfg

`default_nettype wire

// File: rtl/diec_core.sv
// Debounce state, sticky flags and event counters, updated once per accepted word.
// Depends on diec_pkg; the result it presents is the state after this word's update.
`default_nettype none

module diec_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic           raw_level,
  input  wire logic [4:0]     clear_mask,
  input  wire diec_pkg::cfg_t cfg,
  output diec_pkg::res_t      result
);
  import diec_pkg::*;

  logic                                last_raw_r;
  logic [STABLE_W-1:0]                 stable_r, stable_nxt;
  logic                                level_r, level_nxt;
  logic [NUM_EVT-1:0]                  flags_r, flags_nxt;
  logic [NUM_EVT-1:0][COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [NUM_EVT-1:0]                  inc;
  logic                                take;
  logic                                act;

  always_comb begin
    if (raw_level != last_raw_r) begin
      stable_nxt = '0;
    end else if (stable_r == STABLE_MAX) begin
      stable_nxt = stable_r;
    end else begin
      stable_nxt = stable_r + STABLE_W'(1);
    end

    // The raw level is taken once it has been steady for long enough.
    take = (level_r != raw_level) && (stable_nxt >= cfg.debounce_ticks);
    act  = (raw_level != cfg.idle_level);

    flags_nxt = flags_r & ~clear_mask;
    level_nxt = level_r;
    inc       = '0;
    if (take) begin
      level_nxt                  = raw_level;
      flags_nxt[EVT_CHANGED]     = 1'b1;
      flags_nxt[EVT_RISEN]       = raw_level;
      flags_nxt[EVT_FALLEN]      = ~raw_level;
      flags_nxt[EVT_ACTIVATED]   = act;
      flags_nxt[EVT_DEACTIVATED] = ~act;
      inc[EVT_CHANGED]           = 1'b1;
      inc[EVT_RISEN]             = raw_level;
      inc[EVT_FALLEN]            = ~raw_level;
      inc[EVT_ACTIVATED]         = act;
      inc[EVT_DEACTIVATED]       = ~act;
    end

    for (int i = 0; i < NUM_EVT; i++) begin
      cnt_nxt[i] = cnt_r[i] + COUNT_WIDTH'(inc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b0;
      stable_r   <= '0;
      level_r    <= 1'b0;
      flags_r    <= '0;
      cnt_r      <= '0;
    end else if (accept) begin
      last_raw_r <= raw_level;
      stable_r   <= stable_nxt;
      level_r    <= level_nxt;
      flags_r    <= flags_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_comb begin
    result.debounced_level = level_nxt;
    result.flags           = flags_nxt;
    for (int i = 0; i < NUM_EVT; i++) begin
      result.counts[i] = OUT_CNT_W'(cnt_nxt[i]);
    end
  end

  a_restart_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (raw_level != last_raw_r) |=> stable_r == '0)
    else $error("stable count not restarted after a raw change");

  a_level_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(level_r) && $stable(cnt_r))
    else $error("state moved without an accepted word");

  a_change_counts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (level_nxt != level_r) |=>
      cnt_r[EVT_CHANGED] == $past(cnt_r[EVT_CHANGED]) + COUNT_WIDTH'(1))
    else $error("change counter missed an accepted change");

  a_edge_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(flags_r[EVT_RISEN] && flags_r[EVT_FALLEN]))
    else $error("risen and fallen set together");

endmodule : diec_core

`default_nettype wire

// File: rtl/debounced_input_edge_counter_top.sv
// The result for a word is registered into the output register when the word is accepted.
// Throughput: one word per cycle while in_tready is high; the state update is a single pass of compare and increment.
// in_tready is low only while a result sits in the output register and out_tready is low.
// Reset (rst_n low, synchronous) clears the debounce state, flags, counters and output valid,
// and loads debounce_ticks with 50 and idle_level with 1.
`default_nettype none

module debounced_input_edge_counter_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input stream.
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [0] raw_level, [5:1] clear_mask, [7:6] zero
  input  wire logic [diec_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Result stream.
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [0] debounced_level, [1] changed_flag, [2] risen_flag, [3] fallen_flag,
  // [4] activated_flag, [5] deactivated_flag, [21:6] change_count,
  // [37:22] rise_count, [53:38] fall_count, [69:54] activation_count,
  // [85:70] deactivation_count, [87:86] zero
  output logic      [diec_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Configuration port.
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [diec_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [diec_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic      [diec_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                                  cfg_pready
);
  import diec_pkg::*;

  cfg_t                   cfg;
  res_t                   result;
  logic                   in_accept;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  diec_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // A new word is taken whenever the output register is empty or being emptied.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  diec_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .raw_level  (in_tdata[0]),
    .clear_mask (in_tdata[5:1]),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= OUT_TDATA_W'(result);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule : debounced_input_edge_counter_top

`default_nettype wire
